FILE: design/lvn_pkg.sv
package lvn_pkg;

  localparam int LVN_MAX_OCT = 8;
  localparam int LVN_FRAC    = 16;

  localparam logic [31:0] HASH_MUL = 32'h045D9F3B;

  localparam logic [1:0] CFG_SEED = 2'd0;
  localparam logic [1:0] CFG_AMP  = 2'd1;
  localparam logic [1:0] CFG_WAVE = 2'd2;
  localparam logic [1:0] CFG_OCT  = 2'd3;

  // magnitude bits of a coordinate after folding the sign
  localparam int DIV_BITS = 31;
  localparam int HASH_LAT = 5;
  localparam int FADE_LAT = 3;
  localparam int BLEND_LAT = 2;

  function automatic int quo_bits(input int f);
    quo_bits = (f > 16) ? f : 16;
  endfunction

  function automatic int lane_lat(input int f);
    lane_lat = DIV_BITS + 2 + f + HASH_LAT + BLEND_LAT;
  endfunction

  function automatic int comb_lat(input int f, input int mo);
    comb_lat = 2 + $clog2(mo) + quo_bits(f);
  endfunction

  // one restoring division step: {quotient bit, new remainder}
  function automatic logic [16:0] div_step(input logic [15:0] rem, input logic bin,
                                           input logic [15:0] dv);
    logic [16:0] t;
    logic [16:0] d;
    begin
      t = {rem, bin};
      d = t - {1'b0, dv};
      if (t >= {1'b0, dv}) begin
        div_step = {1'b1, d[15:0]};
      end else begin
        div_step = {1'b0, t[15:0]};
      end
    end
  endfunction

  function automatic logic [31:0] sar16(input logic [31:0] v);
    sar16 = {{16{v[31]}}, v[31:16]};
  endfunction

  function automatic logic [31:0] shr16(input logic [31:0] v);
    shr16 = {16'h0000, v[31:16]};
  endfunction

  function automatic logic [31:0] rnd_s(input logic [31:0] v);
    rnd_s = (sar16(v) ^ v) * HASH_MUL;
  endfunction

  function automatic logic [31:0] rnd_u(input logic [31:0] v);
    rnd_u = (shr16(v) ^ v) * HASH_MUL;
  endfunction

endpackage

FILE: design/lattice_value_noise_2d_unit.sv
// 2D lattice value noise with quintic fade, single octave (in_func = 0, scaled by
// amplitude) or fractal mean of up to MAX_OCTAVES octaves (in_func = 1). Fully
// pipelined: a transaction is taken in every cycle that start is high (busy is
// always low) and its result appears on out_noise_value with out_valid after an
// input stage, the integer floor division, a floor-correction stage and the
// fraction division per coordinate, 5 hash stages, 2 blend stages, then a
// weighting stage, the octave adder tree, a divider for the normalization with
// one quotient bit per stage, and an output register. Every octave has its own
// lane. There is no backpressure: results must be captured when out_valid is high.
// Write configuration only when no transaction is in flight.
module lattice_value_noise_2d_unit #(
  parameter int MAX_OCTAVES = lvn_pkg::LVN_MAX_OCT,
  parameter int FRAC_BITS   = lvn_pkg::LVN_FRAC
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_func,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               out_valid,
  output logic [23:0]        out_noise_value
);
  import lvn_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int MO = MAX_OCTAVES;
  localparam int LANE_LAT = lane_lat(F);
  localparam int L  = LANE_LAT + comb_lat(F, MO);

  logic [31:0] seed_r;
  logic [15:0] amp_r;
  logic [15:0] wave_r;
  logic [3:0]  oct_r;
  logic [15:0] w0;
  logic        acc;
  logic [L-1:0] vld_r;
  logic [L-1:0] fn_r;
  logic [MO-1:0][F-1:0] smp;

  assign busy = 1'b0;
  assign acc  = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
      amp_r  <= 16'd256;
      wave_r <= 16'd1;
      oct_r  <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEED: seed_r <= cfg_data;
        CFG_AMP:  amp_r  <= cfg_data[15:0];
        CFG_WAVE: wave_r <= cfg_data[15:0];
        CFG_OCT:  oct_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[L-2:0], acc};
    end
  end

  always_ff @(posedge clk) begin
    fn_r <= {fn_r[L-2:0], in_func};
  end

  assign w0 = (wave_r == 16'd0) ? 16'd1 : wave_r;

  for (genvar i = 0; i < MO; i++) begin : g_lane
    logic [15:0] ws, wl;
    assign ws = w0 >> i;
    assign wl = (ws == 16'd0) ? 16'd1 : ws;
    lvn_oct #(.FRAC_BITS(F)) u_oct (
      .clk(clk), .seed(seed_r), .w(wl),
      .coord_x(in_coord_x), .coord_y(in_coord_y), .smp(smp[i])
    );
  end

  lvn_comb #(.FRAC_BITS(F), .MAX_OCTAVES(MO)) u_comb (
    .clk(clk), .func(fn_r[LANE_LAT-1]), .amplitude(amp_r), .octaves(oct_r),
    .smp(smp), .noise(out_noise_value)
  );

  assign out_valid = vld_r[L-1];

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc, L))
    else $error("result without a transaction accepted at the pipeline depth");

  a_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && fn_r[L-1]) |-> (out_noise_value <= 24'h010000))
    else $error("fractal mean above one");

  a_amp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !fn_r[L-1]) |-> (out_noise_value <= {amp_r, 8'h00}))
    else $error("single octave result above amplitude");

endmodule

FILE: design/lvn_fdiv.sv
module lvn_fdiv #(
  parameter int FRAC_BITS = lvn_pkg::LVN_FRAC
) (
  input  logic                 clk,
  input  logic signed [31:0]   coord,
  input  logic [15:0]          w,
  output logic [31:0]          lat_cell,
  output logic [FRAC_BITS-1:0] frac
);
  import lvn_pkg::*;

  localparam int F = FRAC_BITS;

  logic                neg_r [0:DIV_BITS];
  logic [15:0]         rem_r [0:DIV_BITS];
  logic [DIV_BITS-1:0] mq_r  [0:DIV_BITS];

  logic [15:0]         frem_r [0:F];
  logic [F-1:0]        fq_r   [0:F];
  logic [31:0]         cd_r   [0:F];

  always_ff @(posedge clk) begin
    neg_r[0] <= coord[31];
    mq_r[0]  <= coord[31] ? ~coord[30:0] : coord[30:0];
    rem_r[0] <= '0;
  end

  for (genvar j = 1; j <= DIV_BITS; j++) begin : g_int
    logic [16:0] st;
    assign st = div_step(rem_r[j-1], mq_r[j-1][DIV_BITS-1], w);
    always_ff @(posedge clk) begin
      neg_r[j] <= neg_r[j-1];
      rem_r[j] <= st[15:0];
      mq_r[j]  <= {mq_r[j-1][DIV_BITS-2:0], st[16]};
    end
  end

  // floor correction for negative coordinates
  always_ff @(posedge clk) begin
    cd_r[0]   <= neg_r[DIV_BITS] ? ~{1'b0, mq_r[DIV_BITS]} : {1'b0, mq_r[DIV_BITS]};
    frem_r[0] <= neg_r[DIV_BITS] ? (w - 16'd1 - rem_r[DIV_BITS]) : rem_r[DIV_BITS];
    fq_r[0]   <= '0;
  end

  for (genvar j = 1; j <= F; j++) begin : g_frc
    logic [16:0] st;
    assign st = div_step(frem_r[j-1], 1'b0, w);
    always_ff @(posedge clk) begin
      cd_r[j]   <= cd_r[j-1];
      frem_r[j] <= st[15:0];
      fq_r[j]   <= {fq_r[j-1][F-2:0], st[16]};
    end
  end

  assign lat_cell = cd_r[F];
  assign frac     = fq_r[F];

endmodule

FILE: design/lvn_hash.sv
module lvn_hash #(
  parameter int FRAC_BITS = lvn_pkg::LVN_FRAC
) (
  input  logic                      clk,
  input  logic [31:0]               seed,
  input  logic [31:0]               cell_x,
  input  logic [31:0]               cell_y,
  output logic [3:0][FRAC_BITS-1:0] corner
);
  import lvn_pkg::*;

  localparam int F = FRAC_BITS;

  logic [31:0] iy0_r, iy1_r, jy0_r, jy1_r;
  logic [31:0] cx1_r, cx2_r;
  logic [31:0] in0, in1, cxb;
  logic [3:0][31:0] wd;
  logic [3:0][31:0] h1_r, h2_r, hf;
  logic [3:0][F-1:0] c_r;

  always_ff @(posedge clk) begin
    iy0_r <= rnd_s(cell_y ^ seed);
    iy1_r <= rnd_s((cell_y + 32'd1) ^ seed);
    cx1_r <= cell_x;
    jy0_r <= rnd_s(iy0_r);
    jy1_r <= rnd_s(iy1_r);
    cx2_r <= cx1_r;
  end

  assign in0 = sar16(jy0_r) ^ jy0_r;
  assign in1 = sar16(jy1_r) ^ jy1_r;
  assign cxb = cx2_r + 32'd1;

  // corner order: (x,y) (x+1,y) (x,y+1) (x+1,y+1)
  assign wd[0] = cx2_r ^ in0 ^ seed;
  assign wd[1] = cxb ^ in0 ^ seed;
  assign wd[2] = cx2_r ^ in1 ^ seed;
  assign wd[3] = cxb ^ in1 ^ seed;

  for (genvar k = 0; k < 4; k++) begin : g_cor
    assign hf[k] = shr16(h2_r[k]) ^ h2_r[k];
    always_ff @(posedge clk) begin
      h1_r[k] <= rnd_u(wd[k]);
      h2_r[k] <= rnd_u(h1_r[k]);
      c_r[k]  <= hf[k][22:23-F];
    end
  end

  assign corner = c_r;

endmodule

FILE: design/lvn_fade.sv
module lvn_fade #(
  parameter int FRAC_BITS = lvn_pkg::LVN_FRAC
) (
  input  logic                 clk,
  input  logic [FRAC_BITS-1:0] t,
  output logic [FRAC_BITS:0]   fd
);
  localparam int F = FRAC_BITS;
  localparam logic [F:0]   ONE   = {1'b1, {F{1'b0}}};
  localparam logic [F+3:0] ONE_E = {3'b000, 1'b1, {F{1'b0}}};

  logic [2*F-1:0] p1, p2;
  logic [2*F+3:0] p3;
  logic [F-1:0]   t1_r, t2_r, t3_r;
  logic [F+3:0]   pa, pb, poly_r, rs;
  logic [F:0]     fd_r;

  assign p1 = t * t;
  assign p2 = t2_r * t1_r;
  assign pa = ({4'b0000, t2_r} * (F+4)'(6)) + ((F+4)'(10) << F);
  assign pb = {4'b0000, t1_r} * (F+4)'(15);
  assign p3 = t3_r * poly_r;
  assign rs = p3[2*F+3:F];

  always_ff @(posedge clk) begin
    t1_r   <= t;
    t2_r   <= p1[2*F-1:F];
    t3_r   <= p2[2*F-1:F];
    poly_r <= (pa >= pb) ? (pa - pb) : '0;
    fd_r   <= (rs > ONE_E) ? ONE : rs[F:0];
  end

  assign fd = fd_r;

endmodule

FILE: design/lvn_oct.sv
module lvn_oct #(
  parameter int FRAC_BITS = lvn_pkg::LVN_FRAC
) (
  input  logic                 clk,
  input  logic [31:0]          seed,
  input  logic [15:0]          w,
  input  logic signed [31:0]   coord_x,
  input  logic signed [31:0]   coord_y,
  output logic [FRAC_BITS-1:0] smp
);
  import lvn_pkg::*;

  localparam int F = FRAC_BITS;

  function automatic logic [F-1:0] blend(input logic [F-1:0] a, input logic [F-1:0] b,
                                         input logic [F:0] t);
    logic signed [F:0]     df;
    logic signed [F+1:0]   ts;
    logic signed [2*F+2:0] pr;
    logic signed [F+1:0]   sh;
    logic signed [F+1:0]   sm;
    begin
      df = signed'({1'b0, b}) - signed'({1'b0, a});
      ts = signed'({1'b0, t});
      pr = df * ts;
      sh = signed'(pr[2*F+1:F]);
      sm = signed'({2'b00, a}) + sh;
      blend = sm[F-1:0];
    end
  endfunction

  logic [31:0]       cx, cy;
  logic [F-1:0]      fx, fy;
  logic [F:0]        tx, ty;
  logic [3:0][F-1:0] cor;
  logic [F:0]        tx_d_r [0:1];
  logic [F:0]        ty_d_r [0:2];
  logic [F-1:0]      lo_r, hi_r, smp_r;

  lvn_fdiv #(.FRAC_BITS(F)) u_dx (.clk(clk), .coord(coord_x), .w(w), .lat_cell(cx), .frac(fx));
  lvn_fdiv #(.FRAC_BITS(F)) u_dy (.clk(clk), .coord(coord_y), .w(w), .lat_cell(cy), .frac(fy));

  lvn_hash #(.FRAC_BITS(F)) u_hash (
    .clk(clk), .seed(seed), .cell_x(cx), .cell_y(cy), .corner(cor)
  );

  lvn_fade #(.FRAC_BITS(F)) u_fx (.clk(clk), .t(fx), .fd(tx));
  lvn_fade #(.FRAC_BITS(F)) u_fy (.clk(clk), .t(fy), .fd(ty));

  always_ff @(posedge clk) begin
    tx_d_r[0] <= tx;
    tx_d_r[1] <= tx_d_r[0];
    ty_d_r[0] <= ty;
    ty_d_r[1] <= ty_d_r[0];
    ty_d_r[2] <= ty_d_r[1];
    lo_r      <= blend(cor[0], cor[1], tx_d_r[1]);
    hi_r      <= blend(cor[2], cor[3], tx_d_r[1]);
    smp_r     <= blend(lo_r, hi_r, ty_d_r[2]);
  end

  assign smp = smp_r;

endmodule

FILE: design/lvn_comb.sv
module lvn_comb #(
  parameter int FRAC_BITS   = lvn_pkg::LVN_FRAC,
  parameter int MAX_OCTAVES = lvn_pkg::LVN_MAX_OCT
) (
  input  logic                                clk,
  input  logic                                func,
  input  logic [15:0]                         amplitude,
  input  logic [3:0]                          octaves,
  input  logic [MAX_OCTAVES-1:0][FRAC_BITS-1:0] smp,
  output logic [23:0]                         noise
);
  import lvn_pkg::*;

  localparam int F    = FRAC_BITS;
  localparam int MO   = MAX_OCTAVES;
  localparam int NW   = F + MO;
  localparam int SH   = (F < 16) ? 16 - F : 0;
  localparam int NNW  = NW + SH;
  localparam int QW   = quo_bits(F);
  localparam int LVLS = $clog2(MO);
  localparam int NP   = 1 << LVLS;
  localparam int KW   = $clog2(MO + 1);
  localparam int DL   = LVLS + QW;

  logic [KW-1:0]   k;
  logic [MO:0]     dfull;
  logic [MO-1:0]   d;
  logic [F+15:0]   p0;
  logic [NW-1:0]   tr_r [0:LVLS][0:NP-1];
  logic [23:0]     dm_r [0:DL];
  logic            df_r [0:DL];
  logic [NNW-1:0]  nn;
  logic [MO-1:0]   qrem_r [1:QW];
  logic [QW-1:0]   qmq_r  [1:QW];
  logic [23:0]     qs;
  logic [23:0]     res_r;

  always_comb begin
    if (octaves == 4'd0) begin
      k = KW'(1);
    end else if (32'(octaves) > MO) begin
      k = KW'(MO);
    end else begin
      k = KW'(octaves);
    end
  end

  assign dfull = ((MO+1)'(1) << k) - (MO+1)'(1);
  assign d     = dfull[MO-1:0];
  assign p0    = smp[0] * amplitude;

  always_ff @(posedge clk) begin
    dm_r[0] <= p0[F+15:F-8];
    df_r[0] <= func;
    for (int i = 1; i <= DL; i++) begin
      dm_r[i] <= dm_r[i-1];
      df_r[i] <= df_r[i-1];
    end
  end

  // weighted terms, then a registered adder tree
  for (genvar j = 0; j < NP; j++) begin : g_term
    if (j < MO) begin : g_on
      logic [KW-1:0] sa;
      assign sa = k - KW'(j) - KW'(1);
      always_ff @(posedge clk) begin
        tr_r[0][j] <= (32'(k) > j) ? (NW'(smp[j]) << sa) : '0;
      end
    end else begin : g_off
      always_ff @(posedge clk) begin
        tr_r[0][j] <= '0;
      end
    end
  end

  for (genvar l = 1; l <= LVLS; l++) begin : g_lvl
    for (genvar j = 0; j < NP; j++) begin : g_node
      if (j < (NP >> l)) begin : g_add
        always_ff @(posedge clk) begin
          tr_r[l][j] <= tr_r[l-1][2*j] + tr_r[l-1][2*j+1];
        end
      end else begin : g_nil
        always_ff @(posedge clk) begin
          tr_r[l][j] <= '0;
        end
      end
    end
  end

  if (SH > 0) begin : g_sh
    assign nn = {tr_r[LVLS][0], {SH{1'b0}}};
  end else begin : g_nsh
    assign nn = tr_r[LVLS][0];
  end

  // normalization: divide by 2^k - 1
  for (genvar j = 1; j <= QW; j++) begin : g_div
    logic [MO-1:0] pr;
    logic [QW-1:0] pm;
    logic [16:0]   st;
    if (j == 1) begin : g_first
      assign pr = nn[NNW-1:QW];
      assign pm = nn[QW-1:0];
    end else begin : g_next
      assign pr = qrem_r[j-1];
      assign pm = qmq_r[j-1];
    end
    assign st = div_step(16'(pr), pm[QW-1], 16'(d));
    always_ff @(posedge clk) begin
      qrem_r[j] <= st[MO-1:0];
      qmq_r[j]  <= {pm[QW-2:0], st[16]};
    end
  end

  if (F > 16) begin : g_qhi
    assign qs = 24'(qmq_r[QW][QW-1:F-16]);
  end else begin : g_qlo
    assign qs = 24'(qmq_r[QW]);
  end

  always_ff @(posedge clk) begin
    res_r <= df_r[DL] ? qs : dm_r[DL];
  end

  assign noise = res_r;

endmodule

FILE: tb/lvn_noise_checker.sv
module lvn_noise_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               in_func,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               out_valid,
  input  logic [23:0]        out_noise_value,
  output int                 err_count,
  output int                 pending,
  output int                 n_single,
  output int                 n_fractal
);
  import lvn_pkg::*;

  localparam int          FB     = 16;
  localparam longint      ONE    = 64'd1 << FB;
  localparam logic [31:0] MIXMUL = 32'h045D9F3B;

  logic [31:0] seed_r;
  logic [15:0] amp_r;
  logic [15:0] wave_r;
  logic [3:0]  oct_r;
  logic [23:0] noise_q[$];

  function automatic logic [31:0] asr16(input logic [31:0] v);
    return {{16{v[31]}}, v[31:16]};
  endfunction

  function automatic logic [31:0] mix_arith(input logic [31:0] v);
    logic [31:0] s;
    s = v;
    s = (asr16(s) ^ s) * MIXMUL;
    s = (asr16(s) ^ s) * MIXMUL;
    return asr16(s) ^ s;
  endfunction

  function automatic logic [31:0] mix_logic(input logic [31:0] v);
    logic [31:0] s;
    s = v;
    s = ((s >> 16) ^ s) * MIXMUL;
    s = ((s >> 16) ^ s) * MIXMUL;
    return (s >> 16) ^ s;
  endfunction

  function automatic longint lattice_val(input logic [31:0] cx, input logic [31:0] cy);
    logic [31:0] h;
    h = mix_logic((cx ^ mix_arith(cy ^ seed_r)) ^ seed_r);
    return longint'(h[22:0] >> (23 - FB));
  endfunction

  function automatic void floor_split(input longint c, input longint w,
                                      output logic [31:0] lat_cell, output longint frac);
    longint q;
    longint r;
    q = c / w;
    r = c - q * w;
    if (r < 0) begin
      q = q - 1;
      r = r + w;
    end
    lat_cell = q[31:0];
    frac = (r << FB) / w;
  endfunction

  function automatic longint quintic(input longint t);
    longint t2;
    longint t3;
    longint p;
    longint r;
    t2 = (t * t) >>> FB;
    t3 = (t2 * t) >>> FB;
    p  = 6 * t2 - 15 * t + 10 * ONE;
    if (p < 0) p = 0;
    r = (t3 * p) >>> FB;
    return (r > ONE) ? ONE : r;
  endfunction

  function automatic longint lerp(input longint a, input longint b, input longint t);
    return (a * (ONE - t) + b * t) >>> FB;
  endfunction

  function automatic longint octave_sample(input longint x, input longint y, input longint w);
    logic [31:0] cx;
    logic [31:0] cy;
    longint fx;
    longint fy;
    longint tx;
    longint ty;
    longint lo;
    longint hi;
    floor_split(x, w, cx, fx);
    floor_split(y, w, cy, fy);
    tx = quintic(fx);
    ty = quintic(fy);
    lo = lerp(lattice_val(cx, cy), lattice_val(cx + 32'd1, cy), tx);
    hi = lerp(lattice_val(cx, cy + 32'd1), lattice_val(cx + 32'd1, cy + 32'd1), tx);
    return lerp(lo, hi, ty);
  endfunction

  function automatic logic [23:0] predict_noise(input logic f, input logic signed [31:0] x,
                                                input logic signed [31:0] y);
    longint w;
    longint res;
    longint num;
    longint den;
    int     k;
    w = (wave_r == 0) ? 1 : longint'(wave_r);
    if (!f) begin
      res = (octave_sample(x, y, w) * longint'(amp_r)) >>> (FB - 8);
    end else begin
      k = oct_r;
      if (k < 1) k = 1;
      if (k > LVN_MAX_OCT) k = LVN_MAX_OCT;
      num = 0;
      for (int i = 0; i < k; i++) begin
        num = num + (octave_sample(x, y, w) << (k - 1 - i));
        w = w >> 1;
        if (w == 0) w = 1;
      end
      den = ((longint'(1) << k) - 1) << FB;
      res = (num << 16) / den;
    end
    if (res > 24'hFFFFFF) res = 24'hFFFFFF;
    return res[23:0];
  endfunction

  always @(posedge clk) begin
    logic [23:0] exp_v;
    if (!rst_n) begin
      seed_r <= 32'd0;
      amp_r  <= 16'd256;
      wave_r <= 16'd1;
      oct_r  <= 4'd1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SEED: seed_r <= cfg_data;
          CFG_AMP:  amp_r  <= cfg_data[15:0];
          CFG_WAVE: wave_r <= cfg_data[15:0];
          CFG_OCT:  oct_r  <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        noise_q.push_back(predict_noise(in_func, in_coord_x, in_coord_y));
        if (in_func) n_fractal++;
        else n_single++;
      end
      if (out_valid) begin
        if (noise_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected result noise_value=%h at %0t", out_noise_value, $time);
        end else begin
          exp_v = noise_q.pop_front();
          if (exp_v !== out_noise_value) begin
            err_count++;
            if (err_count <= 10)
              $display("noise_value mismatch: expected %h actual %h at %0t",
                       exp_v, out_noise_value, $time);
          end
        end
      end
    end
    pending = noise_q.size();
  end

  initial begin
    err_count = 0;
    pending   = 0;
    n_single  = 0;
    n_fractal = 0;
  end
endmodule

FILE: tb/tb_lattice_value_noise_2d_unit.sv
module tb_lattice_value_noise_2d_unit;
  import lvn_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_func;
  logic signed [31:0] in_coord_x;
  logic signed [31:0] in_coord_y;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               out_valid;
  logic [23:0]        out_noise_value;
  int                 err_count;
  int                 pending;
  int                 n_single;
  int                 n_fractal;
  int                 idle_pct;

  lattice_value_noise_2d_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_noise_value(out_noise_value)
  );

  lvn_noise_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_noise_value(out_noise_value),
    .err_count(err_count), .pending(pending),
    .n_single(n_single), .n_fractal(n_fractal)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_sample(input logic f, input logic [31:0] x, input logic [31:0] y);
    logic taken;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    in_func    <= f;
    in_coord_x <= x;
    in_coord_y <= y;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_cfg(input logic [31:0] s, input logic [15:0] a, input logic [15:0] w,
                         input logic [3:0] o);
    write_reg(CFG_SEED, s);
    write_reg(CFG_AMP, {16'd0, a});
    write_reg(CFG_WAVE, {16'd0, w});
    write_reg(CFG_OCT, {28'd0, o});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coord(input int span);
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'h7FFFFFFF - $urandom_range(span);
      2: return 32'h80000000 + $urandom_range(span);
      default: return $urandom_range(2 * span) - span;
    endcase
  endfunction

  task automatic random_burst(input int count, input int span);
    repeat (count) send_sample(1'($urandom_range(1)), pick_coord(span), pick_coord(span));
  endtask

  initial begin
    logic [31:0] edge_vals[6];
    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_func    <= 1'b0;
    in_coord_x <= '0;
    in_coord_y <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_SEED;
    cfg_data   <= '0;
    idle_pct   = 0;
    edge_vals = '{32'h0, 32'hFFFFFFFF, 32'h1, 32'h7FFFFFFF, 32'h80000000, 32'h80000001};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration: wavelength 1, cell + 1 wraps at the top coordinate
    for (int i = 0; i < 6; i++) begin
      send_sample(1'b0, edge_vals[i], edge_vals[5 - i]);
      send_sample(1'b1, edge_vals[i], edge_vals[i]);
    end
    random_burst(230, 1000);
    drain();

    set_cfg(32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 4'd8);
    idle_pct = 53;
    for (int i = 0; i < 6; i++) send_sample(i[0], edge_vals[i], edge_vals[(i + 2) % 6]);
    random_burst(240, 200000);
    drain();

    // zero wavelength, zero octaves, zero amplitude
    set_cfg($urandom, 16'd0, 16'd0, 4'd0);
    idle_pct = 0;
    random_burst(250, 100);
    drain();

    set_cfg(32'h0, 16'd256, 16'd7, 4'd15);
    idle_pct = 53;
    random_burst(250, 500);
    drain();

    set_cfg($urandom, 16'($urandom), 16'($urandom_range(300, 1)),
            4'($urandom_range(8, 1)));
    idle_pct = 27;
    random_burst(250, 5000);
    drain();

    // wavelength halves down to the floor of one within the octave count
    set_cfg($urandom, 16'($urandom), 16'd2, 4'd5);
    idle_pct = 0;
    random_burst(250, 50);
    drain();

    $display("Covered %0d single-octave and %0d fractal samples over six register settings",
             n_single, n_fractal);
    if (err_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

FILE: filelist.f
design/lvn_pkg.sv
design/lvn_fdiv.sv
design/lvn_hash.sv
design/lvn_fade.sv
design/lvn_oct.sv
design/lvn_comb.sv
design/lattice_value_noise_2d_unit.sv
tb/lvn_noise_checker.sv
tb/tb_lattice_value_noise_2d_unit.sv
